>>> rtl/cmap_pkg.sv
// Shared types, register indexes and widths of the scalar-to-RGBA color mapper.
// No dependencies; used by the color mapper top level and the testbench.
package cmap_pkg;

  localparam int VALUE_W = 32;
  localparam int CH_W    = 8;
  localparam int IDX_W   = 5;
  localparam int CFG_W   = 3;

  localparam int PALETTE_ENTRIES_DEF = 25;
  localparam int VALUE_FRAC_BITS_DEF = 16;

  // divider lanes: numerator below 300 * 2^33, dividend is 255 times that
  localparam int DIV_N_W = 42;
  localparam int DIV_X_W = 50;
  localparam int DIV_Q_W = 8;

  localparam logic [CFG_W-1:0] CFG_LEVEL_MIN  = 3'd0;
  localparam logic [CFG_W-1:0] CFG_LEVEL_MAX  = 3'd1;
  localparam logic [CFG_W-1:0] CFG_SCALE_MODE = 3'd2;
  localparam logic [CFG_W-1:0] CFG_SHOW_BELOW = 3'd3;
  localparam logic [CFG_W-1:0] CFG_SHOW_ABOVE = 3'd4;

  localparam logic [1:0] MODE_FIVE = 2'd0;
  localparam logic [1:0] MODE_HEAT = 2'd1;
  localparam logic [1:0] MODE_PAL  = 2'd2;
  localparam logic [1:0] MODE_GREY = 2'd3;

  typedef enum logic [2:0] {
    SEG_BELOW = 3'd0,
    SEG_K0    = 3'd1,
    SEG_K1    = 3'd2,
    SEG_K2    = 3'd3,
    SEG_K3    = 3'd4,
    SEG_TOP   = 3'd5
  } seg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

endpackage

>>> rtl/cmap_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cmap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/cmap_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient below 2^QW.
// No dependencies; instantiated by the color mapper top level.
module cmap_div #(
  parameter int XW = 50,
  parameter int DW = 42,
  parameter int QW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [XW-1:0] x_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  logic [XW-1:0] r_q [QW];
  logic [DW-1:0] d_q [QW];
  logic [QW-1:0] q_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [XW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [XW-1:0] dsh;
    logic [QW-1:0] q_set;

    if (s == 0) begin : g_first
      assign r_in = x_i;
      assign d_in = d_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[s-1];
      assign d_in = d_q[s-1];
      assign q_in = q_q[s-1];
    end

    assign dsh = XW'(d_in) << B;

    always_comb begin
      q_set    = q_in;
      q_set[B] = 1'b1;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s] <= d_in;
        if (r_in >= dsh) begin
          r_q[s] <= r_in - dsh;
          q_q[s] <= q_set;
        end else begin
          r_q[s] <= r_in;
          q_q[s] <= q_in;
        end
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

>>> rtl/scalar_to_rgba_colormap_top.sv
// Top level of the scalar-to-RGBA color mapper: config registers, segment
// select, palette RAM, two divider lanes, output skid. Uses cmap_pkg,
// cmap_ram and cmap_div.
//
// Usage:
//   Config port (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   level_min, level_max, scale_mode, show_below, show_above; always ready.
//   Write only while the block is idle.
//   Input channel (in_valid_i/in_stall_o) takes one word per cycle while
//   in_stall_o is low. Opcode 0 converts sample_value_i to a color, opcode 1
//   writes a palette entry and gives no output word.
//   Output channel (out_valid_o/out_stall_i) carries red, green, blue, opacity.
//   A word passes the input register, one segment stage, eight divider
//   stages (one quotient bit each) and one output register.
//   Throughput is one word per cycle while in_stall_o is low; the palette RAM
//   is read and written in the same stage, one access per cycle, so ordering
//   is kept. Reset loads the default levels and marks all palette entries
//   empty (they read as zero); no clearing pass is needed.
//   When the receiver stalls, one word goes into the skid register; in_stall_o
//   rises with it and the whole pipeline holds until the skid drains.
module scalar_to_rgba_colormap_top #(
  parameter int PALETTE_ENTRIES = cmap_pkg::PALETTE_ENTRIES_DEF,
  parameter int VALUE_FRAC_BITS = cmap_pkg::VALUE_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cmap_pkg::CFG_W-1:0]       cfg_index_i,
  input  logic [cmap_pkg::VALUE_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic signed [cmap_pkg::VALUE_W-1:0] sample_value_i,
  input  logic [cmap_pkg::CH_W-1:0]        alpha_in_i,
  input  logic [cmap_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [cmap_pkg::CH_W-1:0]        entry_red_i,
  input  logic [cmap_pkg::CH_W-1:0]        entry_green_i,
  input  logic [cmap_pkg::CH_W-1:0]        entry_blue_i,
  input  logic [cmap_pkg::CH_W-1:0]        entry_alpha_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cmap_pkg::CH_W-1:0]        red_o,
  output logic [cmap_pkg::CH_W-1:0]        green_o,
  output logic [cmap_pkg::CH_W-1:0]        blue_o,
  output logic [cmap_pkg::CH_W-1:0]        opacity_o
);

  localparam int AW  = $clog2(PALETTE_ENTRIES > 1 ? PALETTE_ENTRIES : 2);
  localparam int IW  = cmap_pkg::VALUE_W - VALUE_FRAC_BITS;
  localparam int RW  = IW + 9;
  localparam int NW  = cmap_pkg::DIV_N_W;
  localparam int XW  = cmap_pkg::DIV_X_W;
  localparam int QW  = cmap_pkg::DIV_Q_W;
  localparam int LAT = cmap_pkg::DIV_Q_W;
  localparam int PW  = 4 * cmap_pkg::CH_W;
  localparam logic [63:0]   RECIP64 = (64'd1 << IW) / PALETTE_ENTRIES;
  localparam logic [IW-1:0] RECIP   = RECIP64[IW-1:0];
  localparam logic [RW-1:0] PAL_N   = RW'(PALETTE_ENTRIES);

  typedef struct packed {
    logic                  wr;
    cmap_pkg::seg_e        seg;
    logic [cmap_pkg::CH_W-1:0] alpha;
    logic [PW-1:0]         pal;
  } side_t;

  // config registers
  logic signed [31:0] lvl_min_q, lvl_max_q;
  logic [1:0]         mode_q;
  logic               show_below_q, show_above_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_min_q    <= '0;
      lvl_max_q    <= 32'sd65536;
      mode_q       <= cmap_pkg::MODE_FIVE;
      show_below_q <= 1'b0;
      show_above_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cmap_pkg::CFG_LEVEL_MIN:  lvl_min_q    <= cfg_data_i;
        cmap_pkg::CFG_LEVEL_MAX:  lvl_max_q    <= cfg_data_i;
        cmap_pkg::CFG_SCALE_MODE: mode_q       <= cfg_data_i[1:0];
        cmap_pkg::CFG_SHOW_BELOW: show_below_q <= cfg_data_i[0];
        cmap_pkg::CFG_SHOW_ABOVE: show_above_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage 1
  logic               s1_vld_q, s1_op_q;
  logic signed [31:0] s1_v_q;
  logic [7:0]         s1_alpha_q;
  logic [4:0]         s1_idx_q;
  logic [PW-1:0]      s1_ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      s1_op_q    <= opcode_i;
      s1_v_q     <= sample_value_i;
      s1_alpha_q <= alpha_in_i;
      s1_idx_q   <= entry_index_i;
      s1_ent_q   <= {entry_red_i, entry_green_i, entry_blue_i, entry_alpha_i};
    end
  end

  logic               heat;
  logic signed [36:0] d_w, base_w, vs_w;
  logic signed [36:0] bnd [5];
  cmap_pkg::seg_e     seg_w;
  logic signed [36:0] n_w;
  logic               found;
  logic [IW-1:0]      pal_x;
  logic [2*IW-1:0]    pal_prod;

  assign heat = (mode_q == cmap_pkg::MODE_HEAT);

  always_comb begin
    d_w    = 37'(lvl_max_q) - 37'(lvl_min_q);
    base_w = heat ? 37'sd3 * 37'(lvl_min_q) : 37'sd4 * 37'(lvl_min_q);
    vs_w   = heat ? 37'sd3 * 37'(s1_v_q) : 37'sd4 * 37'(s1_v_q);
    for (int k = 0; k < 5; k++) begin
      bnd[k] = base_w + d_w * $signed(37'(k));
    end
    seg_w = cmap_pkg::SEG_TOP;
    n_w   = '0;
    found = 1'b0;
    if (vs_w < base_w) begin
      seg_w = cmap_pkg::SEG_BELOW;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (!found && (k < 3 || !heat) && vs_w < bnd[k+1]) begin
          found = 1'b1;
          seg_w = cmap_pkg::seg_e'(3'(k + 1));
          n_w   = vs_w - bnd[k];
        end
      end
    end
  end

  assign pal_x    = s1_v_q[31:VALUE_FRAC_BITS];
  assign pal_prod = (2*IW)'(pal_x) * (2*IW)'(RECIP);

  // stage 2
  logic            s2_vld_q, s2_op_q, s2_neg_q;
  cmap_pkg::seg_e  s2_seg_q;
  logic [32:0]     s2_n_q;
  logic [7:0]      s2_alpha_q;
  logic [4:0]      s2_idx_q;
  logic [PW-1:0]   s2_ent_q;
  logic [IW-1:0]   s2_x_q;
  logic [2*IW-1:0] s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q    <= s1_op_q;
      s2_neg_q   <= s1_v_q[31];
      s2_seg_q   <= seg_w;
      s2_n_q     <= n_w[32:0];
      s2_alpha_q <= s1_alpha_q;
      s2_idx_q   <= s1_idx_q;
      s2_ent_q   <= s1_ent_q;
      s2_x_q     <= pal_x;
      s2_prod_q  <= pal_prod;
    end
  end

  // divider operands
  logic [NW-1:0] dd, nn, a_num, a_den, b_num, b_den;
  logic [XW-1:0] a_x, b_x;
  logic [QW-1:0] qa, qb;

  assign dd = NW'(d_w[32:0]);
  assign nn = NW'(s2_n_q);

  always_comb begin
    a_num = nn;
    a_den = dd;
    b_num = nn;
    b_den = dd;
    if (heat) begin
      case (s2_seg_q)
        cmap_pkg::SEG_K0: begin
          a_num = dd + nn;
          a_den = dd * NW'(2);
          b_num = nn;
          b_den = dd * NW'(3);
        end
        cmap_pkg::SEG_K1: begin
          a_num = nn;
          a_den = dd;
          b_num = dd * NW'(99) + nn * NW'(100);
          b_den = dd * NW'(300);
        end
        cmap_pkg::SEG_K2: begin
          a_num = nn * NW'(66);
          a_den = dd * NW'(100);
          b_num = dd * NW'(198) + nn * NW'(100);
          b_den = dd * NW'(300);
        end
        default: ;
      endcase
    end else begin
      case (s2_seg_q)
        cmap_pkg::SEG_K1, cmap_pkg::SEG_K3: a_num = dd - nn;
        default: a_num = nn;
      endcase
    end
  end

  assign a_x = (XW'(a_num) << 8) - XW'(a_num);
  assign b_x = (XW'(b_num) << 8) - XW'(b_num);

  cmap_div #(.XW(XW), .DW(NW), .QW(QW)) u_div_a (
    .clk_i (clk_i), .en_i (en), .x_i (a_x), .d_i (a_den), .q_o (qa)
  );

  cmap_div #(.XW(XW), .DW(NW), .QW(QW)) u_div_b (
    .clk_i (clk_i), .en_i (en), .x_i (b_x), .d_i (b_den), .q_o (qb)
  );

  // palette index: value mod entries, by reciprocal and one correction
  logic [IW-1:0]  pal_q;
  logic [RW-1:0]  pal_rem, pal_rem_fix;
  logic [AW-1:0]  pal_raddr, pal_waddr;
  logic           pal_we;
  logic [PALETTE_ENTRIES-1:0] pal_vld_q;
  logic           pal_hit_q;
  logic [PW-1:0]  pal_rdata;

  assign pal_q       = s2_prod_q[2*IW-1:IW];
  assign pal_rem     = RW'(s2_x_q) - RW'(pal_q) * PAL_N;
  assign pal_rem_fix = (pal_rem >= PAL_N) ? pal_rem - PAL_N : pal_rem;
  assign pal_raddr   = s2_neg_q ? '0 : pal_rem_fix[AW-1:0];
  assign pal_waddr   = AW'(s2_idx_q);
  assign pal_we      = en && s2_vld_q && s2_op_q && (int'(s2_idx_q) < PALETTE_ENTRIES);

  cmap_ram #(.WIDTH(PW), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (s2_ent_q),
    .re_i    (en),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      pal_hit_q <= 1'b0;
    end else begin
      if (pal_we) begin
        pal_vld_q[pal_waddr] <= 1'b1;
      end
      if (en) begin
        pal_hit_q <= pal_vld_q[pal_raddr];
      end
    end
  end

  // side pipeline, aligned with the divider stages
  logic [LAT-1:0] side_vld_q;
  side_t          side_q [LAT];
  side_t          side_d0;
  side_t          side_d1;

  always_comb begin
    side_d0.wr    = s2_op_q;
    side_d0.seg   = s2_seg_q;
    side_d0.alpha = s2_alpha_q;
    side_d0.pal   = '0;
  end

  always_comb begin
    side_d1     = side_q[0];
    side_d1.pal = pal_hit_q ? pal_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_vld_q <= '0;
    end else if (en) begin
      side_vld_q <= {side_vld_q[LAT-2:0], s2_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d0;
      side_q[1] <= side_d1;
      for (int i = 2; i < LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // color assembly
  side_t           last;
  logic            fin_v;
  cmap_pkg::rgba_t fin;
  logic [7:0]      a;

  assign last  = side_q[LAT-1];
  assign fin_v = side_vld_q[LAT-1] && !last.wr;
  assign a     = last.alpha;

  always_comb begin
    fin = '0;
    case (mode_q)
      cmap_pkg::MODE_FIVE: begin
        case (last.seg)
          cmap_pkg::SEG_BELOW: fin = {8'd0, 8'd0, 8'd255, show_below_q ? a : 8'd0};
          cmap_pkg::SEG_K0:    fin = {8'd0, qa, 8'd255, a};
          cmap_pkg::SEG_K1:    fin = {8'd0, 8'd255, qa, a};
          cmap_pkg::SEG_K2:    fin = {qa, 8'd255, 8'd0, a};
          cmap_pkg::SEG_K3:    fin = {8'd255, qa, 8'd0, a};
          default:             fin = {8'd255, 8'd0, 8'd0, show_above_q ? a : 8'd0};
        endcase
      end
      cmap_pkg::MODE_HEAT: begin
        case (last.seg)
          cmap_pkg::SEG_BELOW: fin = {8'd127, 8'd0, 8'd0, 8'd0};
          cmap_pkg::SEG_K0:    fin = {qa, 8'd0, 8'd0, qb};
          cmap_pkg::SEG_K1:    fin = {8'd255, qa, 8'd0, qb};
          cmap_pkg::SEG_K2:    fin = {8'd255, 8'd255, qa, qb};
          default:             fin = {8'd255, 8'd255, 8'd168, 8'd255};
        endcase
      end
      cmap_pkg::MODE_PAL: fin = last.pal;
      default:            fin = {8'd127, 8'd127, 8'd127, 8'd127};
    endcase
  end

  // output register and skid
  logic            out_v_q;
  cmap_pkg::rgba_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= fin_v;
      end
    end else if (en && fin_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : fin;
    end else if (en && fin_v) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_o       = out_q.red;
  assign green_o     = out_q.green;
  assign blue_o      = out_q.blue;
  assign opacity_o   = out_q.alpha;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a word while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without an output stall");

  a_pal_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |=> pal_vld_q[$past(pal_waddr)])
    else $error("palette write did not mark its entry");

  a_pal_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !s2_op_q && !s2_neg_q) |-> (pal_rem_fix < PAL_N))
    else $error("palette index out of range");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for scalar_to_rgba_colormap_top: a directed table then random
// words through the input channel, each result checked against an internal color predictor.
// Depends on cmap_pkg and the RTL of the color mapper.
`timescale 1ns / 1ps

module tb_top;

  localparam int NPAL = 25;
  localparam int LATENCY = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic             op;
    logic [31:0]      val;
    logic [7:0]       ain;
    logic [4:0]       idx;
    logic [7:0]       er, eg, eb, ea;
  } word_t;

  typedef struct {
    logic              known;
    cmap_pkg::rgba_t   col;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cmap_pkg::CFG_W-1:0] cfg_index_i = '0;
  logic [cmap_pkg::VALUE_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = 1'b0;
  logic signed [cmap_pkg::VALUE_W-1:0] sample_value_i = '0;
  logic [cmap_pkg::CH_W-1:0] alpha_in_i = '0;
  logic [cmap_pkg::IDX_W-1:0] entry_index_i = '0;
  logic [cmap_pkg::CH_W-1:0] entry_red_i = '0, entry_green_i = '0, entry_blue_i = '0;
  logic [cmap_pkg::CH_W-1:0] entry_alpha_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [cmap_pkg::CH_W-1:0] red_o, green_o, blue_o, opacity_o;

  scalar_to_rgba_colormap_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  longint lvl_min, lvl_max;
  logic [1:0] mode;
  logic sh_below, sh_above;
  cmap_pkg::rgba_t pal [NPAL];
  cmap_pkg::rgba_t color_q [$];
  int errors = 0, ncolors = 0, nwords = 0, cycles = 0;
  bit idle_on = 1'b1;

  function automatic longint frac255(longint num, longint den);
    return (255 * num) / den;
  endfunction

  function automatic cmap_pkg::rgba_t map_color(logic signed [31:0] sv, logic [7:0] a);
    cmap_pkg::rgba_t c;
    longint v, d, lo, hi, n;
    int e;
    v = sv;
    d = lvl_max - lvl_min;
    c = '{8'd127, 8'd127, 8'd127, 8'd127};
    if (mode == cmap_pkg::MODE_FIVE) begin
      c = '{8'd255, 8'd0, 8'd0, sh_above ? a : 8'd0};
      if (4 * v < 4 * lvl_min) begin
        c = '{8'd0, 8'd0, 8'd255, sh_below ? a : 8'd0};
      end else begin
        for (int k = 0; k < 4; k++) begin
          lo = (4 - k) * lvl_min + k * lvl_max;
          hi = (3 - k) * lvl_min + (k + 1) * lvl_max;
          if (4 * v < hi) begin
            n = 4 * v - lo;
            case (k)
              0: c = '{8'd0, 8'(frac255(n, d)), 8'd255, a};
              1: c = '{8'd0, 8'd255, 8'(frac255(d - n, d)), a};
              2: c = '{8'(frac255(n, d)), 8'd255, 8'd0, a};
              default: c = '{8'd255, 8'(frac255(d - n, d)), 8'd0, a};
            endcase
            break;
          end
        end
      end
    end else if (mode == cmap_pkg::MODE_HEAT) begin
      c = '{8'd255, 8'd255, 8'd168, 8'd255};
      if (3 * v < 3 * lvl_min) begin
        c = '{8'd127, 8'd0, 8'd0, 8'd0};
      end else begin
        for (int k = 0; k < 3; k++) begin
          lo = (3 - k) * lvl_min + k * lvl_max;
          hi = (2 - k) * lvl_min + (k + 1) * lvl_max;
          if (3 * v < hi) begin
            n = 3 * v - lo;
            case (k)
              0: c = '{8'(frac255(d + n, 2 * d)), 8'd0, 8'd0, 8'(frac255(n, 3 * d))};
              1: c = '{8'd255, 8'(frac255(n, d)), 8'd0,
                       8'(frac255(99 * d + 100 * n, 300 * d))};
              default: c = '{8'd255, 8'd255, 8'(frac255(66 * n, 100 * d)),
                             8'(frac255(198 * d + 100 * n, 300 * d))};
            endcase
            break;
          end
        end
      end
    end else if (mode == cmap_pkg::MODE_PAL) begin
      e = 0;
      if (v >= 0) e = int'((v >>> cmap_pkg::VALUE_FRAC_BITS_DEF) % NPAL);
      c = pal[e];
    end
    return c;
  endfunction

  task automatic write_reg(logic [cmap_pkg::CFG_W-1:0] r, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      cmap_pkg::CFG_LEVEL_MIN:  lvl_min = longint'(signed'(data));
      cmap_pkg::CFG_LEVEL_MAX:  lvl_max = longint'(signed'(data));
      cmap_pkg::CFG_SCALE_MODE: mode = data[1:0];
      cmap_pkg::CFG_SHOW_BELOW: sh_below = data[0];
      default:                  sh_above = data[0];
    endcase
  endtask

  task automatic set_scale(logic [31:0] mn, logic [31:0] mx, logic [1:0] m, bit b, bit t);
    write_reg(cmap_pkg::CFG_LEVEL_MIN, mn);
    write_reg(cmap_pkg::CFG_LEVEL_MAX, mx);
    write_reg(cmap_pkg::CFG_SCALE_MODE, {30'd0, m});
    write_reg(cmap_pkg::CFG_SHOW_BELOW, {31'd0, b});
    write_reg(cmap_pkg::CFG_SHOW_ABOVE, {31'd0, t});
  endtask

  task automatic drain();
    wait (color_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // drives one word, predicts its color or records its palette write, waits for acceptance
  task automatic send(word_t w, row_t r);
    cmap_pkg::rgba_t c;
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= w.op;
    sample_value_i <= w.val;
    alpha_in_i <= w.ain;
    entry_index_i <= w.idx;
    entry_red_i <= w.er;
    entry_green_i <= w.eg;
    entry_blue_i <= w.eb;
    entry_alpha_i <= w.ea;
    do @(posedge clk_i); while (in_stall_o);
    nwords++;
    if (w.op) begin
      if (w.idx < NPAL) pal[w.idx] = '{w.er, w.eg, w.eb, w.ea};
    end else begin
      c = map_color(w.val, w.ain);
      if (r.known && c != r.col) begin
        $error("predictor disagrees with table row: %h vs %h", c, r.col);
        errors++;
      end
      color_q.push_back(c);
    end
  endtask

  function automatic word_t conv(logic [31:0] v, logic [7:0] a);
    return '{1'b0, v, a, 5'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  endfunction

  function automatic word_t pwr(logic [4:0] i, logic [31:0] rgba);
    return '{1'b1, $urandom, 8'($urandom), i, rgba[31:24], rgba[23:16], rgba[15:8], rgba[7:0]};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= idle_on ? ($urandom_range(99) < 32) : 1'b0;
  end

  always @(posedge clk_i) begin
    cmap_pkg::rgba_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (color_q.size() == 0) begin
        $error("unexpected word: %h %h %h %h", red_o, green_o, blue_o, opacity_o);
        errors++;
      end else begin
        e = color_q.pop_front();
        ncolors++;
        if (red_o !== e.red) begin
          $error("red: expected %0d got %0d", e.red, red_o); errors++;
        end
        if (green_o !== e.green) begin
          $error("green: expected %0d got %0d", e.green, green_o); errors++;
        end
        if (blue_o !== e.blue) begin
          $error("blue: expected %0d got %0d", e.blue, blue_o); errors++;
        end
        if (opacity_o !== e.alpha) begin
          $error("opacity: expected %0d got %0d", e.alpha, opacity_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  word_t dir_w [$];
  row_t dir_r [$];

  task automatic add(word_t w, bit k, cmap_pkg::rgba_t c);
    dir_w.push_back(w);
    dir_r.push_back('{k, c});
  endtask

  task automatic rand_phase(int count, logic [1:0] m);
    word_t w;
    longint span, base;
    base = lvl_min;
    span = lvl_max - lvl_min;
    if (span <= 0) span = 65536;
    for (int i = 0; i < count; i++) begin
      w = conv($urandom, 8'($urandom));
      case ($urandom_range(9))
        0, 1: w.val = $urandom;
        2: w = pwr(5'($urandom), $urandom);
        default: begin
          if (m == cmap_pkg::MODE_PAL) begin
            w.val = {1'($urandom_range(1)), 15'($urandom), 16'($urandom)};
          end else begin
            w.val = 32'(base - span / 8 +
                        longint'($urandom_range(1000)) * (span + span / 4) / 1000);
          end
        end
      endcase
      send(w, '{1'b0, '0});
    end
  endtask

  initial begin
    cmap_pkg::rgba_t z;
    z = '0;
    lvl_min = 0; lvl_max = 65536; mode = cmap_pkg::MODE_FIVE; sh_below = 0; sh_above = 0;
    foreach (pal[i]) pal[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: default levels, five-color mode, alpha masked outside
    add(conv(32'h8000_0000, 8'hFF), 1, '{8'd0, 8'd0, 8'd255, 8'd0});
    add(conv(32'h7FFF_FFFF, 8'hFF), 1, '{8'd255, 8'd0, 8'd0, 8'd0});
    add(conv(32'h0001_0000, 8'hAA), 1, '{8'd255, 8'd0, 8'd0, 8'd0});
    add(conv(32'h0000_0000, 8'h55), 1, '{8'd0, 8'd0, 8'd255, 8'h55});
    add(conv(32'h0000_4000, 8'hFF), 1, '{8'd0, 8'd255, 8'd255, 8'hFF});
    add(conv(32'h0000_8000, 8'hFF), 1, '{8'd0, 8'd255, 8'd0, 8'hFF});
    add(conv(32'h0000_C000, 8'h01), 1, '{8'd255, 8'd255, 8'd0, 8'h01});
    add(conv(32'h0000_2000, 8'h80), 0, z);
    add(conv(32'h0000_E000, 8'h80), 0, z);
    add(pwr(5'd31, 32'hFFFF_FFFF), 0, z);
    add(pwr(5'd24, 32'h1122_3344), 0, z);
    add(pwr(5'd0, 32'hFFFF_FFFF), 0, z);
    for (int i = 0; i < dir_w.size(); i++) send(dir_w[i], dir_r[i]);
    in_valid_i <= 1'b0;
    drain();

    // palette: negative, wrap, large index, empty entry
    set_scale(32'd0, 32'd65536, cmap_pkg::MODE_PAL, 1'b0, 1'b0);
    dir_w.delete(); dir_r.delete();
    add(conv(32'hFFFF_FFFF, 8'h00), 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    add(conv(32'h0018_0000, 8'h00), 1, '{8'h11, 8'h22, 8'h33, 8'h44});
    add(conv(32'h0019_8000, 8'h00), 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    add(conv(32'h7FFF_FFFF, 8'h00), 0, z);
    add(conv(32'h0003_0000, 8'h00), 1, '{8'h00, 8'h00, 8'h00, 8'h00});
    for (int i = 0; i < dir_w.size(); i++) send(dir_w[i], dir_r[i]);
    in_valid_i <= 1'b0;
    drain();

    // heat: extremes, then empty range, then grey
    set_scale(32'd0, 32'd196608, cmap_pkg::MODE_HEAT, 1'b1, 1'b1);
    send(conv(32'h8000_0000, 8'h00), '{1'b1, '{8'd127, 8'd0, 8'd0, 8'd0}});
    send(conv(32'h7FFF_FFFF, 8'h00), '{1'b1, '{8'd255, 8'd255, 8'd168, 8'd255}});
    send(conv(32'h0000_0000, 8'h00), '{1'b1, '{8'd127, 8'd0, 8'd0, 8'd0}});
    send(conv(32'h0001_8000, 8'h00), '{1'b0, z});
    in_valid_i <= 1'b0;
    drain();
    set_scale(32'd65536, 32'd65536, cmap_pkg::MODE_FIVE, 1'b1, 1'b1);
    send(conv(32'h0000_FFFF, 8'h77), '{1'b1, '{8'd0, 8'd0, 8'd255, 8'h77}});
    send(conv(32'h0001_0000, 8'h77), '{1'b1, '{8'd255, 8'd0, 8'd0, 8'h77}});
    in_valid_i <= 1'b0;
    drain();
    write_reg(cmap_pkg::CFG_SCALE_MODE, {30'd0, cmap_pkg::MODE_GREY});
    send(conv($urandom, 8'($urandom)), '{1'b1, '{8'd127, 8'd127, 8'd127, 8'd127}});
    in_valid_i <= 1'b0;
    drain();

    // random phases over several settings, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      logic [31:0] mn, mx;
      logic [1:0] m;
      m = 2'(ph % 4);
      case (ph)
        0: begin mn = 32'h8000_0000; mx = 32'h7FFF_FFFF; end
        1: begin mn = 32'h7FFF_FFFF; mx = 32'h8000_0000; end
        2: begin mn = -32'sd100; mx = 32'd7; end
        default: begin
          mn = 32'($signed($urandom_range(400000)) - 200000);
          mx = mn + $urandom_range(600000);
        end
      endcase
      set_scale(mn, mx, m, 1'($urandom), 1'($urandom));
      idle_on = (ph != 5);
      rand_phase(110, m);
      in_valid_i <= 1'b0;
      drain();
    end
    idle_on = 1'b1;
    drain();

    $display("Covered %0d input words and %0d colors in all four modes,", nwords, ncolors);
    $display("including inverted and extreme ranges and palette writes.");
    if (errors == 0 && color_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
